// File: hw/rtl/slot_position_change_classifier_assert.svh
// assertion macros for the slot position change classifier
`ifndef SLOT_POSITION_CHANGE_CLASSIFIER_ASSERT_SVH
`define SLOT_POSITION_CHANGE_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot classifier check failed");
// next-cycle implication
`define SPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot classifier check failed");
`else
`define SPC_ASSERT_NOW(label, ante, cons)
`define SPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/spc_pkg.sv
// shared constants and types of the slot position change classifier
package spc_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = 6;
	localparam int KC_W   = 7;
	localparam int POS_W  = 32;
	localparam int THR_W  = 31;
	localparam int SQ_W   = 2 * THR_W;
	localparam int ACC_W  = SQ_W + 2;

	typedef enum logic [1:0] {
		CHG_UNCHANGED = 2'd0,
		CHG_FRESH     = 2'd1,
		CHG_MIGRATED  = 2'd2
	} change_t;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
		logic             reported;
	} entry_t;

	// control of the shared square and accumulate unit
	typedef struct packed {
		logic clear;
		logic vld;
		logic thr;
	} mac_ctl_t;

endpackage

// File: hw/rtl/spc_ifs.sv
// word channels of the slot position change classifier

interface spc_item_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [spc_pkg::SLOT_W-1:0]       slot;
	logic signed [spc_pkg::POS_W-1:0] pos_x;
	logic signed [spc_pkg::POS_W-1:0] pos_y;
	logic signed [spc_pkg::POS_W-1:0] pos_z;
	logic                             was_reported;

	modport source (output valid, cmd, slot, pos_x, pos_y, pos_z, was_reported, input ready);
	modport sink (input valid, cmd, slot, pos_x, pos_y, pos_z, was_reported, output ready);
endinterface

interface spc_result_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 change;
	logic [spc_pkg::SLOT_W-1:0] slot_echo;
	logic [spc_pkg::SLOT_W-1:0] source_slot;
	logic                       source_valid;

	modport source (output valid, change, slot_echo, source_slot, source_valid, input ready);
	modport sink (input valid, change, slot_echo, source_slot, source_valid, output ready);
endinterface

// File: hw/rtl/spc_table.sv
// slot table memory: one write port, one registered read port
module spc_table (
	input  logic                       clk,
	input  logic                       we,
	input  logic [spc_pkg::SLOT_W-1:0] waddr,
	input  spc_pkg::entry_t            wdata,
	input  logic                       re,
	input  logic [spc_pkg::SLOT_W-1:0] raddr,
	output spc_pkg::entry_t            rdata
);

	spc_pkg::entry_t mem [spc_pkg::SLOTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/spc_sqacc.sv
// shared squarer with accumulator for the distance check
module spc_sqacc (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spc_pkg::mac_ctl_t         ctl,
	input  logic [spc_pkg::THR_W-1:0] opnd,
	output logic                      le
);

	logic [spc_pkg::SQ_W-1:0]  prod_s1;
	logic                      vld_s1;
	logic                      thr_s1;
	logic [spc_pkg::SQ_W-1:0]  thr_q;
	logic [spc_pkg::ACC_W-1:0] acc_q;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld && !ctl.clear;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= spc_pkg::SQ_W'(opnd) * spc_pkg::SQ_W'(opnd);
		thr_s1  <= ctl.thr;
	end

	// threshold square or running sum of squares
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			if (thr_s1) begin
				thr_q <= prod_s1;
			end else begin
				acc_q <= acc_q + spc_pkg::ACC_W'(prod_s1);
			end
		end
	end

	assign le = acc_q <= spc_pkg::ACC_W'(thr_q);

endmodule

// File: hw/rtl/slot_position_change_classifier.sv
// top level of the slot position change classifier
//
// A load word writes its slot into the table. A classify word ends at the
// known count check when the slot lies at or beyond the known count, at the
// read of its own entry when the slot is not reported, at the distance check
// when it lies within the respawn distance, and otherwise when the table is
// searched for an exact position match; the search reads one entry a cycle
// through the table's single read port, from the highest known slot downwards.
// The squared distance is formed by one shared 31 x 31 squarer over four steps.
// The input is not ready while a classify word is in work or while its result
// waits for the output register.
module slot_position_change_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spc_pkg::THR_W-1:0]     cfg_wdata,
	spc_item_if.sink                      item,
	spc_result_if.source                  result
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SELF = 5'b00010,
		S_SQ   = 5'b00100,
		S_WALK = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [spc_pkg::THR_W-1:0]      thr_q;
	logic [spc_pkg::KC_W-1:0]       known_count_q;
	logic [spc_pkg::SLOT_W-1:0]     slot_q;
	logic [spc_pkg::POS_W-1:0]      px_q, py_q, pz_q;
	logic [spc_pkg::THR_W-1:0]      dx_q, dy_q, dz_q;
	logic                           big_q;
	logic [2:0]                     step_q;
	logic [spc_pkg::SLOT_W-1:0]     widx_q;
	logic                           issue_done_q;
	logic                           cmp_vld_q;
	logic                           cmp_last_q;
	logic [spc_pkg::SLOT_W-1:0]     cmp_idx_q;
	spc_pkg::change_t               res_change_q;
	logic [spc_pkg::SLOT_W-1:0]     res_src_q;
	logic                           res_srcv_q;
	logic                           out_vld_q;
	spc_pkg::change_t               out_change_q;
	logic [spc_pkg::SLOT_W-1:0]     out_slot_q;
	logic [spc_pkg::SLOT_W-1:0]     out_src_q;
	logic                           out_srcv_q;

	logic                           accept;
	logic                           issue;
	logic                           re;
	logic [spc_pkg::SLOT_W-1:0]     raddr;
	logic                           we;
	spc_pkg::entry_t                wdata;
	spc_pkg::entry_t                rdata;
	spc_pkg::mac_ctl_t              mac_ctl;
	logic [spc_pkg::THR_W-1:0]      mac_opnd;
	logic                           le;
	logic                           match;
	logic                           out_free;
	logic [spc_pkg::POS_W:0]        dx_raw, dy_raw, dz_raw;
	logic [spc_pkg::POS_W:0]        dx_abs, dy_abs, dz_abs;

	assign accept   = item.valid && item.ready;
	assign item.ready = state_q == S_IDLE;
	assign out_free = !out_vld_q || result.ready;

	// table access: loads write at accept, classify reads its own slot, then walks
	assign we = accept && item.cmd == spc_pkg::CMD_LOAD
		&& {1'b0, item.slot} < spc_pkg::KC_W'(spc_pkg::SLOTS);
	assign wdata = '{x: item.pos_x, y: item.pos_y, z: item.pos_z,
		reported: item.was_reported};
	assign issue = state_q == S_WALK && !issue_done_q;
	assign re    = (accept && item.cmd == spc_pkg::CMD_CLASSIFY) || issue;
	assign raddr = accept ? item.slot : widx_q;

	spc_table u_table (
		.clk   (clk),
		.we    (we),
		.waddr (item.slot),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// coordinate differences against the slot's stored position, 33 bits
	always_comb begin
		dx_raw = {px_q[spc_pkg::POS_W-1], px_q} - {rdata.x[spc_pkg::POS_W-1], rdata.x};
		dy_raw = {py_q[spc_pkg::POS_W-1], py_q} - {rdata.y[spc_pkg::POS_W-1], rdata.y};
		dz_raw = {pz_q[spc_pkg::POS_W-1], pz_q} - {rdata.z[spc_pkg::POS_W-1], rdata.z};
		dx_abs = dx_raw[spc_pkg::POS_W] ? -dx_raw : dx_raw;
		dy_abs = dy_raw[spc_pkg::POS_W] ? -dy_raw : dy_raw;
		dz_abs = dz_raw[spc_pkg::POS_W] ? -dz_raw : dz_raw;
	end

	// squarer operand sequence: threshold, then dx, dy, dz
	always_comb begin
		mac_ctl.clear = state_q == S_SELF;
		mac_ctl.vld   = state_q == S_SQ && step_q < 3'd4;
		mac_ctl.thr   = step_q == 3'd0;
		unique case (step_q[1:0])
			2'd0:    mac_opnd = thr_q;
			2'd1:    mac_opnd = dx_q;
			2'd2:    mac_opnd = dy_q;
			default: mac_opnd = dz_q;
		endcase
	end

	spc_sqacc u_sqacc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.opnd   (mac_opnd),
		.le     (le)
	);

	// exact match of a walked entry
	assign match = rdata.reported && rdata.x == px_q && rdata.y == py_q && rdata.z == pz_q;

	// configuration register and known count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= '0;
			known_count_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (we) begin
				known_count_q <= spc_pkg::KC_W'(item.slot) + spc_pkg::KC_W'(1);
			end
		end
	end

	// held classify word and difference magnitudes
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= item.slot;
			px_q   <= item.pos_x;
			py_q   <= item.pos_y;
			pz_q   <= item.pos_z;
		end
		if (state_q == S_SELF) begin
			dx_q  <= dx_abs[spc_pkg::THR_W-1:0];
			dy_q  <= dy_abs[spc_pkg::THR_W-1:0];
			dz_q  <= dz_abs[spc_pkg::THR_W-1:0];
			big_q <= |dx_abs[spc_pkg::POS_W:spc_pkg::THR_W]
				|| |dy_abs[spc_pkg::POS_W:spc_pkg::THR_W]
				|| |dz_abs[spc_pkg::POS_W:spc_pkg::THR_W];
		end
	end

	// walk tracking of the entry now in the read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_q <= 1'b0;
		end else begin
			cmp_vld_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q  <= widx_q;
		cmp_last_q <= widx_q == '0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			widx_q       <= '0;
			issue_done_q <= 1'b0;
			res_change_q <= spc_pkg::CHG_FRESH;
			res_src_q    <= '0;
			res_srcv_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.cmd == spc_pkg::CMD_CLASSIFY) begin
						res_src_q  <= '0;
						res_srcv_q <= 1'b0;
						if (spc_pkg::KC_W'(item.slot) >= known_count_q) begin
							res_change_q <= spc_pkg::CHG_FRESH;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SELF;
						end
					end
				end
				S_SELF: begin
					step_q <= '0;
					if (!rdata.reported) begin
						res_change_q <= spc_pkg::CHG_FRESH;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						if (!big_q && le) begin
							res_change_q <= spc_pkg::CHG_UNCHANGED;
							state_q      <= S_DONE;
						end else begin
							widx_q       <= spc_pkg::SLOT_W'(known_count_q - spc_pkg::KC_W'(1));
							issue_done_q <= 1'b0;
							state_q      <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (issue) begin
						widx_q <= widx_q - spc_pkg::SLOT_W'(1);
						if (widx_q == '0) begin
							issue_done_q <= 1'b1;
						end
					end
					if (cmp_vld_q && match) begin
						// highest matching slot decides; a match on itself is fresh
						if (cmp_idx_q != slot_q) begin
							res_change_q <= spc_pkg::CHG_MIGRATED;
							res_src_q    <= cmp_idx_q;
							res_srcv_q   <= 1'b1;
						end else begin
							res_change_q <= spc_pkg::CHG_FRESH;
						end
						state_q <= S_DONE;
					end else if (cmp_vld_q && cmp_last_q) begin
						res_change_q <= spc_pkg::CHG_FRESH;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_change_q <= res_change_q;
			out_slot_q   <= slot_q;
			out_src_q    <= res_src_q;
			out_srcv_q   <= res_srcv_q;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.change       = out_change_q;
	assign result.slot_echo    = out_slot_q;
	assign result.source_slot  = out_src_q;
	assign result.source_valid = out_srcv_q;

`include "slot_position_change_classifier_assert.svh"

	`SPC_ASSERT_NOW(a_known_count_range, 1'b1, known_count_q <= spc_pkg::KC_W'(spc_pkg::SLOTS))
	`SPC_ASSERT_NEXT(a_classify_blocks, accept && item.cmd == spc_pkg::CMD_CLASSIFY, !item.ready)
	`SPC_ASSERT_NOW(a_source_flag, result.valid, result.source_valid == (result.change == spc_pkg::CHG_MIGRATED))
	`SPC_ASSERT_NOW(a_source_not_self, result.valid && result.source_valid, result.source_slot != result.slot_echo)

endmodule
